### hdl/gsm1d_pkg.sv
// ----------------------------------------------------------------------------
// gsm1d_pkg: shared types and constants of the 1-D Gaussian smoothing unit
// Sizes of the sample window, the coefficient format, the accumulator and the
// configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package gsm1d_pkg;

    localparam int MAX_HALF    = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BINS    = 1024;

    localparam int WIN_LEN   = 2 * MAX_HALF + 1;
    localparam int COEF_W    = 16;
    localparam int NUM_COEF  = 4;
    localparam int HW_W      = 2;
    localparam int CNT_W     = $clog2(MAX_BINS + 1);
    localparam int PROD_W    = SAMPLE_BITS + COEF_W;
    localparam int SUM_W     = PROD_W + $clog2(WIN_LEN);
    localparam int Q_W       = SUM_W - COEF_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [COEF_W-1:0]      t_coef;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef t_sample t_window  [WIN_LEN];
    typedef t_coef   t_weights [WIN_LEN];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH       = 3'd0,
        CFG_COEFF_CENTER     = 3'd1,
        CFG_COEFF_SIDE_ONE   = 3'd2,
        CFG_COEFF_SIDE_TWO   = 3'd3,
        CFG_COEFF_SIDE_THREE = 3'd4
    } t_cfg_idx;

    // Handshake state of one pipeline stage
    typedef struct packed {
        logic vld;
        logic last;
    } t_beat_ctl;

endpackage

`default_nettype wire

### hdl/gsm1d_cfg.sv
// ----------------------------------------------------------------------------
// gsm1d_cfg: configuration registers and tap weight map
// Holds half width and the four coefficients, and spreads them over the
// window positions so that each position carries its own weight.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm1d_cfg
    import gsm1d_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    output logic      [HW_W-1:0]       o_half_width,
    output t_weights                   o_weight
);

    logic [HW_W-1:0] r_half_width;
    t_coef           r_coef [NUM_COEF];

    assign o_cfg_ready  = 1'b1;
    assign o_half_width = r_half_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= '0;
            r_coef[0]    <= '1;
            r_coef[1]    <= '0;
            r_coef[2]    <= '0;
            r_coef[3]    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HALF_WIDTH:       r_half_width <= i_cfg_data[HW_W-1:0];
                CFG_COEFF_CENTER:     r_coef[0]    <= i_cfg_data[COEF_W-1:0];
                CFG_COEFF_SIDE_ONE:   r_coef[1]    <= i_cfg_data[COEF_W-1:0];
                CFG_COEFF_SIDE_TWO:   r_coef[2]    <= i_cfg_data[COEF_W-1:0];
                CFG_COEFF_SIDE_THREE: r_coef[3]    <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Position k sits |k - h| bins from the center; beyond 2h it is unused.
    always_comb begin
        int h;
        int d;
        h = int'(r_half_width);
        for (int k = 0; k < WIN_LEN; k++) begin
            d = (k > h) ? (k - h) : (h - k);
            if (k <= 2 * h && d < NUM_COEF) begin
                o_weight[k] = r_coef[d[1:0]];
            end else begin
                o_weight[k] = '0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/gsm1d_window.sv
// ----------------------------------------------------------------------------
// gsm1d_window: sample window and frame sequencer
// Shifts samples into the window, counts bins of the frame, decides which
// steps produce a result, and pushes zeros after the last sample of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm1d_window
    import gsm1d_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [HW_W-1:0]  i_half_width,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_sample          i_sample,
    input  wire logic             i_last,
    input  wire logic             i_dn_ready,
    output t_window               o_window,
    output t_beat_ctl             o_ctl
);

    t_sample          r_win [WIN_LEN];
    logic [CNT_W-1:0] r_count;
    logic             r_clr;
    logic             r_flush;
    logic [HW_W-1:0]  r_fl_left;
    t_beat_ctl        r_ctl;

    logic             a_free;
    logic             accept;
    logic             step;
    t_sample          shift_in;
    logic [CNT_W-1:0] n_count;
    logic             emit;
    logic             last_step;

    assign a_free   = !r_ctl.vld || i_dn_ready;
    assign o_ready  = a_free && !r_flush;
    assign accept   = i_valid && o_ready;
    assign step     = accept || (r_flush && a_free);
    assign shift_in = accept ? i_sample : '0;

    always_comb begin
        if (r_clr) begin
            n_count = CNT_W'(1);
        end else if (r_count == CNT_W'(MAX_BINS)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
    end

    assign emit      = n_count > CNT_W'(i_half_width);
    assign last_step = accept ? (i_last && i_half_width == '0)
                              : (r_fl_left == HW_W'(1));

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_win[0] <= shift_in;
            for (int k = 1; k < WIN_LEN; k++) begin
                r_win[k] <= r_clr ? t_sample'(0) : r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_clr     <= 1'b1;
            r_flush   <= 1'b0;
            r_fl_left <= '0;
            r_ctl     <= '0;
        end else begin
            if (a_free) begin
                r_ctl <= step ? t_beat_ctl'{vld: emit, last: last_step} : '0;
            end
            if (step) begin
                r_count <= n_count;
                r_clr   <= 1'b0;
                if (accept && i_last) begin
                    if (i_half_width == '0) begin
                        r_clr <= 1'b1;
                    end else begin
                        r_flush   <= 1'b1;
                        r_fl_left <= i_half_width;
                    end
                end else if (!accept) begin
                    // zero-padding step after the frame end
                    r_fl_left <= r_fl_left - HW_W'(1);
                    if (r_fl_left == HW_W'(1)) begin
                        r_flush <= 1'b0;
                        r_clr   <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_window = r_win;
    assign o_ctl    = r_ctl;

endmodule

`default_nettype wire

### hdl/gsm1d_filter.sv
// ----------------------------------------------------------------------------
// gsm1d_filter: tap products, sum, rounding and saturation
// Three register stages: per-tap products, the product sum, then the rounded
// and saturated result that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm1d_filter
    import gsm1d_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_window          i_window,
    input  wire t_weights         i_weight,
    input  wire t_beat_ctl        i_ctl,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_sample               o_data,
    output logic                  o_last
);

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_W - 1);

    t_prod     r_prod [WIN_LEN];
    t_beat_ctl r_b_ctl;
    t_sum      r_sum;
    t_beat_ctl r_c_ctl;
    t_sample   r_out;
    t_beat_ctl r_d_ctl;

    logic      b_free;
    logic      c_free;
    logic      d_free;

    logic signed [PROD_W:0] prod_full [WIN_LEN];
    t_sum                   n_sum;
    t_sum                   rounded;
    logic signed [Q_W-1:0]  quot;
    t_sample                n_out;

    assign d_free  = !r_d_ctl.vld || i_ready;
    assign c_free  = !r_c_ctl.vld || d_free;
    assign b_free  = !r_b_ctl.vld || c_free;
    assign o_ready = b_free;

    always_comb begin
        for (int k = 0; k < WIN_LEN; k++) begin
            prod_full[k] = $signed(i_window[k]) * $signed({1'b0, i_weight[k]});
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < WIN_LEN; k++) begin
            n_sum = n_sum + SUM_W'(r_prod[k]);
        end
    end

    // Round half up, then clamp to the sample range.
    always_comb begin
        rounded = r_sum + $signed(ROUND_HALF);
        quot    = Q_W'(rounded >>> COEF_W);
        if (quot[Q_W-1:SAMPLE_BITS-1] == '0 || quot[Q_W-1:SAMPLE_BITS-1] == '1) begin
            n_out = quot[SAMPLE_BITS-1:0];
        end else if (quot[Q_W-1]) begin
            n_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && i_ctl.vld) begin
            for (int k = 0; k < WIN_LEN; k++) begin
                r_prod[k] <= prod_full[k][PROD_W-1:0];
            end
        end
        if (c_free && r_b_ctl.vld) begin
            r_sum <= n_sum;
        end
        if (d_free && r_c_ctl.vld) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_d_ctl <= '0;
        end else begin
            if (b_free) begin
                r_b_ctl <= i_ctl;
            end
            if (c_free) begin
                r_c_ctl <= r_b_ctl;
            end
            if (d_free) begin
                r_d_ctl <= r_c_ctl;
            end
        end
    end

    assign o_valid = r_d_ctl.vld;
    assign o_last  = r_d_ctl.last;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### hdl/gaussian_smooth_1d_unit.sv
// ----------------------------------------------------------------------------
// gaussian_smooth_1d_unit: zero-padded symmetric Gaussian FIR smoother
// Smooths frames of signed height samples with a kernel of 2*half_width+1 taps.
// ----------------------------------------------------------------------------
// One sample beat is taken per clock while a frame streams in and the output
// does not stall; each result passes four register stages (window, products,
// sum, round/saturate) before it is offered on the output, and results lag
// the input by half_width bins. After the beat with tlast the input holds
// tready low while the window sequencer pushes half_width zero padding steps
// and flushes the last results, and longer while the output stalls.
// Every frame gives exactly one result per sample, the last one flagged by
// tlast. Configuration must be written only while the unit is idle; the unit
// itself does not enforce this.
`default_nettype none

module gaussian_smooth_1d_unit
    import gsm1d_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write: index selects half_width, center, side one, two, three
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [TDATA_W-1:0]    i_s_axis_tdata,   // [15:0] height
    input  wire logic                  i_s_axis_tlast,   // frame_end
    // output stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [TDATA_W-1:0]    o_m_axis_tdata,   // [15:0] smoothed
    output logic                       o_m_axis_tlast    // frame_done
);

    logic [HW_W-1:0] half_width;
    t_weights        weight;
    t_window         window;
    t_beat_ctl       win_ctl;
    logic            filt_ready;
    t_sample         smoothed;

    gsm1d_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_half_width (half_width),
        .o_weight     (weight)
    );

    gsm1d_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_half_width (half_width),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_sample     (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_last       (i_s_axis_tlast),
        .i_dn_ready   (filt_ready),
        .o_window     (window),
        .o_ctl        (win_ctl)
    );

    gsm1d_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window     (window),
        .i_weight     (weight),
        .i_ctl        (win_ctl),
        .o_ready      (filt_ready),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (smoothed),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = TDATA_W'($unsigned(smoothed));

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gaussian_smooth_1d_unit
// Streams framed height samples through the smoother. A behavioral predictor
// of the zero-padded kernel keeps its own window and register copies and
// works out every smoothed bin. Each output beat is checked in order against
// that prediction while both stream sides insert random gaps.
// ----------------------------------------------------------------------------

import gsm1d_pkg::*;

localparam t_sample SAMPLE_MAX = t_sample'((1 <<< (SAMPLE_BITS - 1)) - 1);
localparam t_sample SAMPLE_MIN = t_sample'(-(1 <<< (SAMPLE_BITS - 1)));

typedef struct packed {
    t_sample smoothed;
    logic    frame_done;
} t_smoothed_bin;

class smooth_scoreboard;
    int            half;
    t_coef         weight[NUM_COEF];
    t_sample       window[WIN_LEN];   // [0] holds the newest sample
    int            seen;
    t_smoothed_bin pending[$];
    int            errors;
    int            checked;
    int            samples;
    int            frames;

    function new();
        int k;
        half = 0;
        weight[0] = '1;
        for (k = 1; k < NUM_COEF; k++) weight[k] = '0;
        for (k = 0; k < WIN_LEN; k++) window[k] = '0;
        seen    = 0;
        errors  = 0;
        checked = 0;
        samples = 0;
        frames  = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_HALF_WIDTH:       half      = int'(data[HW_W-1:0]);
            CFG_COEFF_CENTER:     weight[0] = data;
            CFG_COEFF_SIDE_ONE:   weight[1] = data;
            CFG_COEFF_SIDE_TWO:   weight[2] = data;
            CFG_COEFF_SIDE_THREE: weight[3] = data;
            default: ;  // unmapped index: drop
        endcase
    endfunction

    function void shift_in(t_sample s);
        int k;
        for (k = WIN_LEN - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = s;
    endfunction

    // Smoothed value of the bin half places behind the newest sample
    function t_sample filter_bin();
        longint acc;
        int     k;
        int     d;
        acc = 0;
        for (k = 0; k <= 2 * half; k++) begin
            d = (k > half) ? k - half : half - k;
            acc += longint'(weight[d]) * longint'(window[k]);
        end
        // round half up to whole units, then clamp
        acc = (acc + 32768) >>> COEF_W;
        if (acc > longint'(SAMPLE_MAX)) acc = longint'(SAMPLE_MAX);
        if (acc < longint'(SAMPLE_MIN)) acc = longint'(SAMPLE_MIN);
        return t_sample'(acc);
    endfunction

    function void note_sample(t_sample h, logic last);
        t_sample       fresh[$];
        t_smoothed_bin bin;
        int            cnt;
        int            k;
        shift_in(h);
        samples++;
        if (seen < MAX_BINS) seen++;
        cnt = seen;
        if (cnt > half) fresh.push_back(filter_bin());
        if (last) begin
            // pad past the frame end with zeros and flush the trailing bins
            for (k = 0; k < half; k++) begin
                shift_in('0);
                cnt++;
                if (cnt > half) fresh.push_back(filter_bin());
            end
            for (k = 0; k < WIN_LEN; k++) window[k] = '0;
            seen = 0;
            frames++;
        end
        for (k = 0; k < fresh.size(); k++) begin
            bin.smoothed   = fresh[k];
            bin.frame_done = last && (k == fresh.size() - 1);
            pending.push_back(bin);
        end
    endfunction

    task report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_smoothed(t_sample got, logic done);
        t_smoothed_bin want;
        if (pending.size() == 0) begin
            report($sformatf("unexpected bin %0d, frame_done %0b", got, done));
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got !== want.smoothed)
            report($sformatf("bin %0d: smoothed %0d, want %0d", checked, got, want.smoothed));
        if (done !== want.frame_done)
            report($sformatf("bin %0d: frame_done %0b, want %0b", checked, done,
                             want.frame_done));
    endtask
endclass

module testbench;

    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 48;
    localparam int PRESSURE_FRAME = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [TDATA_W-1:0]   i_s_axis_tdata;   // [15:0] height
    logic                 i_s_axis_tlast;   // frame_end
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [TDATA_W-1:0]   o_m_axis_tdata;   // [15:0] smoothed
    logic                 o_m_axis_tlast;   // frame_done

    int src_idle_pct;
    int sink_idle_pct;
    int hold_requests;

    smooth_scoreboard sb = new();

    gaussian_smooth_1d_unit dut (.*);

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_coef rand_coef();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return t_coef'($urandom);
            default: return t_coef'($urandom_range(0, 20000));
        endcase
    endfunction

    function automatic t_sample rand_height();
        int v;
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2: begin
                v = $urandom_range(0, 64);
                return t_sample'(v - 32);
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_sample(t_sample h, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= TDATA_W'($unsigned(h));
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(h, last);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.load_reg(idx, data);
    endtask

    // Drop the input, let every expected bin out, then let the pipeline drain
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_kernel(int h, t_coef c0, t_coef c1, t_coef c2, t_coef c3);
        logic [CFG_DAT_W-1:0] hw_data;
        // bits above the half-width field carry random junk
        hw_data = CFG_DAT_W'($urandom);
        hw_data[HW_W-1:0] = HW_W'(h);
        wait_idle();
        write_reg(CFG_HALF_WIDTH, hw_data);
        write_reg(CFG_COEFF_CENTER, c0);
        write_reg(CFG_COEFF_SIDE_ONE, c1);
        write_reg(CFG_COEFF_SIDE_TWO, c2);
        write_reg(CFG_COEFF_SIDE_THREE, c3);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n_items);
        int sent;
        int len;
        int k;
        int frame_no;
        sent     = 0;
        frame_no = 0;
        while (sent < n_items) begin
            if (frame_no % 3 == 0)
                set_kernel($urandom_range(0, MAX_HALF), rand_coef(), rand_coef(),
                           rand_coef(), rand_coef());
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            for (k = 0; k < len; k++) send_sample(rand_height(), k == len - 1);
            sent += len;
            frame_no++;
        end
    endtask

    // Output side: check each beat, then pick tready for the next cycle
    initial begin : sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_smoothed(t_sample'(o_m_axis_tdata[SAMPLE_BITS-1:0]), o_m_axis_tlast);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d bins outstanding", WATCHDOG_LIMIT,
                 sb.pending.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int k;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_requests = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset kernel: no side taps, center just below one
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(t_sample'(0), 1'b0);
        send_sample(t_sample'(1), 1'b0);
        send_sample(t_sample'(-1), 1'b1);

        // widest kernel with every weight at full scale: clamp both ways
        set_kernel(MAX_HALF, '1, '1, '1, '1);
        for (k = 0; k < 8; k++) send_sample((k < 4) ? SAMPLE_MAX : SAMPLE_MIN, k == 7);
        // frames shorter than the half width
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(-100), 1'b1);
        send_sample(SAMPLE_MAX, 1'b1);

        // writes to unmapped indexes must leave the kernel alone
        set_kernel(1, 16'h8000, 16'h4000, 16'h2000, 16'h1000);
        for (k = int'(CFG_COEFF_SIDE_THREE) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), '1);
        i_cfg_valid <= 1'b0;
        send_sample(t_sample'(1000), 1'b0);
        send_sample(t_sample'(-2000), 1'b0);
        send_sample(t_sample'(3000), 1'b0);
        send_sample(t_sample'(-4000), 1'b1);

        // retune the weights halfway through a frame; the window is kept
        for (k = 0; k < 3; k++) send_sample(rand_height(), 1'b0);
        wait_idle();
        write_reg(CFG_COEFF_CENTER, '1);
        write_reg(CFG_COEFF_SIDE_ONE, '0);
        i_cfg_valid <= 1'b0;
        send_sample(rand_height(), 1'b0);
        send_sample(rand_height(), 1'b1);

        src_idle_pct  = 38;
        sink_idle_pct = 53;
        random_phase(PHASE_ITEMS);
        src_idle_pct  = 53;
        sink_idle_pct = 38;
        random_phase(PHASE_ITEMS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(PHASE_ITEMS);

        // hold the output off while the input keeps coming until it backs up
        set_kernel(MAX_HALF, 16'd25000, 16'd15000, 16'd4500, 16'd700);
        hold_requests++;
        for (k = 0; k < PRESSURE_FRAME; k++) send_sample(rand_height(), k == PRESSURE_FRAME - 1);

        wait_idle();
        $display("covered %0d frames, %0d samples, %0d smoothed bins checked",
                 sb.frames, sb.samples, sb.checked);
        $display("half widths 0 to 3, clamped sums, short frames, %0d-cycle output stall",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/gsm1d_pkg.sv
hdl/gsm1d_cfg.sv
hdl/gsm1d_window.sv
hdl/gsm1d_filter.sv
hdl/gaussian_smooth_1d_unit.sv
tb/testbench.sv
